### design/spst_pkg.sv
// spst_pkg: shared types and constants of the sorted preset station table
// used by sorted_preset_station_table; depends on nothing

package spst_pkg;

  // table depth default and fixed field widths
  localparam int unsigned MAX_STATIONS_DEF = 32;
  localparam int unsigned FREQ_W           = 14;
  localparam int unsigned IDX_OUT_W        = 6;
  localparam int unsigned MODE_W           = 2;

  localparam logic [FREQ_W-1:0] STATION_LIMIT = 14'd11000;
  localparam logic [FREQ_W-1:0] RESET_DEFAULT = 14'd10000;
  localparam logic [MODE_W-1:0] MODE_PRESET   = 2'd2;

  // request command codes
  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_UP        = 3'd2,
    CMD_DOWN      = 3'd3,
    CMD_SET_MODE  = 3'd4,
    CMD_SET_FREQ  = 3'd5,
    CMD_MARK      = 3'd6,
    CMD_SAVE_DONE = 3'd7
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SHIFT_DN,
    ST_LOAD,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [FREQ_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [FREQ_W-1:0]    frequency;
    logic [IDX_OUT_W-1:0] preset_index;
    logic [MODE_W-1:0]    tune_mode;
    logic [IDX_OUT_W-1:0] station_count;
    logic                 save_pending;
  } rsp_t;

endpackage

### design/spst_ram.sv
// spst_ram: generic single write port, single read port RAM, registered read
// standalone; no package needed

module spst_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/sorted_preset_station_table.sv
// sorted_preset_station_table: ascending preset station list with tuning state
// depends on spst_pkg and spst_ram
//
// Usage: one request (command, value) enters on req_valid_i/req_ready_o and
// exactly one response leaves on rsp_valid_o/rsp_ready_i, carrying ok and the
// tuning state after the command. req_ready_o is high only while the
// sequencer is idle; one request is worked on at a time.
// Insert and delete walk the table one entry per cycle through the single
// RAM read port; search and shift together cover at most N+1 entries
// (N = entries in the table).
// Reset: the table holds one entry (10000), which is also the current
// frequency; index 0, manual mode, nothing pending. No clearing pass: only
// entry 0 carries a valid bit, other entries are always written before read.
// The configuration channel is always ready; the written default only takes
// effect through a reset, which loads the fixed default, so it is dropped.
// Stall: a finished response waits in the output register; the next request
// may be accepted and worked on, and waits to finish until the register frees.

module sorted_preset_station_table #(
  parameter int unsigned MAX_STATIONS = spst_pkg::MAX_STATIONS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  spst_pkg::req_t              req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output spst_pkg::rsp_t              rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [spst_pkg::FREQ_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_STATIONS);
  localparam int unsigned CW = $clog2(MAX_STATIONS + 1);
  localparam int unsigned FW = spst_pkg::FREQ_W;

  spst_pkg::state_e state_q, state_d;
  spst_pkg::cmd_e   cmd_q, cmd_d;
  logic [FW-1:0]    val_q, val_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    preset_q, preset_d;
  logic [FW-1:0]    freq_q, freq_d;
  logic [spst_pkg::MODE_W-1:0] mode_q, mode_d;
  logic             sdirty_q, sdirty_d;
  logic             ldirty_q, ldirty_d;
  logic             ok_q, ok_d;
  logic             e0_valid_q, e0_valid_d;
  logic             fix_q;
  logic             rsp_valid_q, rsp_valid_d;
  spst_pkg::rsp_t   rsp_q, rsp_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [FW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [FW-1:0]    ram_rdata;
  logic [FW-1:0]    rd_data;

  logic             accept;
  logic             out_free;
  logic             hit;
  logic             past;
  logic             last;
  logic             full;
  logic             empty;
  logic             at_pos;
  logic [CW-1:0]    ptr_inc;
  logic [CW-1:0]    ptr_dec;
  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    preset_ext;
  logic [CW-1:0]    step_idx;
  logic             step_up;

  // station storage
  spst_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_STATIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry 0 reads as the reset default until first written
  assign rd_data = fix_q ? spst_pkg::RESET_DEFAULT : ram_rdata;

  // handshakes
  assign req_ready_o = (state_q == spst_pkg::ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

  // shared compare unit and counter arithmetic
  assign hit        = (rd_data == val_q);
  assign past       = (rd_data > val_q);
  assign ptr_inc    = ptr_q + CW'(1);
  assign ptr_dec    = ptr_q - CW'(1);
  assign last       = (ptr_inc == count_q);
  assign at_pos     = (ptr_q == pos_q);
  assign full       = (count_q == CW'(MAX_STATIONS));
  assign empty      = (count_q == '0);
  assign cnt_m1     = count_q - CW'(1);
  assign preset_ext = CW'(preset_q);

  // wrapped preset step
  assign step_up = (req_i.command == spst_pkg::CMD_UP);
  always_comb begin
    if (step_up) begin
      step_idx = (preset_ext + CW'(1) >= count_q) ? '0 : preset_ext + CW'(1);
    end else begin
      step_idx = (preset_ext == '0 || preset_ext >= count_q) ? cnt_m1
                                                             : preset_ext - CW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spst_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.command)
            spst_pkg::CMD_INSERT: begin
              if (req_i.value > spst_pkg::STATION_LIMIT) begin
                state_d = spst_pkg::ST_DONE;
              end else if (empty) begin
                state_d = spst_pkg::ST_PUT;
              end else begin
                state_d = spst_pkg::ST_SCAN;
              end
            end
            spst_pkg::CMD_DELETE: begin
              state_d = empty ? spst_pkg::ST_DONE : spst_pkg::ST_SCAN;
            end
            spst_pkg::CMD_UP, spst_pkg::CMD_DOWN: begin
              state_d = empty ? spst_pkg::ST_DONE : spst_pkg::ST_LOAD;
            end
            default: state_d = spst_pkg::ST_DONE;
          endcase
        end
      end
      spst_pkg::ST_SCAN: begin
        if (cmd_q == spst_pkg::CMD_INSERT) begin
          if (hit || ((past || last) && full)) begin
            state_d = spst_pkg::ST_DONE;
          end else if (past) begin
            state_d = spst_pkg::ST_SHIFT_UP;
          end else if (last) begin
            state_d = spst_pkg::ST_PUT;
          end
        end else begin
          if (hit) begin
            state_d = last ? spst_pkg::ST_DONE : spst_pkg::ST_SHIFT_DN;
          end else if (past || last) begin
            state_d = spst_pkg::ST_DONE;
          end
        end
      end
      spst_pkg::ST_SHIFT_UP: begin
        if (at_pos) begin
          state_d = spst_pkg::ST_PUT;
        end
      end
      spst_pkg::ST_PUT:      state_d = spst_pkg::ST_DONE;
      spst_pkg::ST_SHIFT_DN: begin
        if (last) begin
          state_d = spst_pkg::ST_DONE;
        end
      end
      spst_pkg::ST_LOAD:     state_d = spst_pkg::ST_DONE;
      spst_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = spst_pkg::ST_IDLE;
        end
      end
      default: state_d = spst_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cmd_d       = cmd_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    count_d     = count_q;
    preset_d    = preset_q;
    freq_d      = freq_q;
    mode_d      = mode_q;
    sdirty_d    = sdirty_q;
    ldirty_d    = ldirty_q;
    ok_d        = ok_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[AW-1:0];
    ram_wdata   = rd_data;
    ram_raddr   = '0;

    case (state_q)
      spst_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d = req_i.command;
          val_d = req_i.value;
          ok_d  = 1'b1;
          ptr_d = '0;
          pos_d = '0;
          case (req_i.command)
            spst_pkg::CMD_INSERT: begin
              if (req_i.value > spst_pkg::STATION_LIMIT) begin
                ok_d = 1'b0;
              end
            end
            spst_pkg::CMD_DELETE: begin
              if (empty) begin
                ok_d = 1'b0;
              end
            end
            spst_pkg::CMD_UP, spst_pkg::CMD_DOWN: begin
              sdirty_d  = 1'b1;
              preset_d  = empty ? '0 : step_idx[AW-1:0];
              ram_raddr = step_idx[AW-1:0];
            end
            spst_pkg::CMD_SET_MODE: begin
              mode_d   = (req_i.value > FW'(spst_pkg::MODE_PRESET))
                         ? spst_pkg::MODE_PRESET : req_i.value[spst_pkg::MODE_W-1:0];
              sdirty_d = 1'b1;
            end
            spst_pkg::CMD_SET_FREQ: begin
              freq_d   = req_i.value;
              sdirty_d = 1'b1;
            end
            spst_pkg::CMD_MARK: sdirty_d = 1'b1;
            spst_pkg::CMD_SAVE_DONE: begin
              if (sdirty_q) begin
                sdirty_d = 1'b0;
              end else begin
                ldirty_d = 1'b0;
              end
            end
            default: ok_d = 1'b1;
          endcase
        end
      end
      // one entry per cycle; the next address goes out while this one compares
      spst_pkg::ST_SCAN: begin
        ram_raddr = ptr_inc[AW-1:0];
        ptr_d     = ptr_inc;
        if (cmd_q == spst_pkg::CMD_INSERT) begin
          if (!hit && (past || last) && full) begin
            ok_d = 1'b0;
          end else if (!hit && past) begin
            pos_d     = ptr_q;
            ptr_d     = cnt_m1;
            ram_raddr = cnt_m1[AW-1:0];
          end else if (!hit && last) begin
            pos_d = count_q;
          end
        end else begin
          if (hit && last) begin
            count_d  = cnt_m1;
            ldirty_d = 1'b1;
          end else if (!hit && (past || last)) begin
            ok_d = 1'b0;
          end
        end
      end
      // move entries up by one, top first
      spst_pkg::ST_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_inc[AW-1:0];
        ram_raddr = ptr_dec[AW-1:0];
        ptr_d     = ptr_dec;
      end
      spst_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        ldirty_d  = 1'b1;
      end
      // close the gap, bottom first
      spst_pkg::ST_SHIFT_DN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_dec[AW-1:0];
        ram_raddr = ptr_inc[AW-1:0];
        ptr_d     = ptr_inc;
        if (last) begin
          count_d  = cnt_m1;
          ldirty_d = 1'b1;
        end
      end
      spst_pkg::ST_LOAD: freq_d = rd_data;
      spst_pkg::ST_DONE: begin
        if (out_free) begin
          rsp_valid_d         = 1'b1;
          rsp_d.ok            = ok_q;
          rsp_d.frequency     = freq_q;
          rsp_d.preset_index  = spst_pkg::IDX_OUT_W'(preset_q);
          rsp_d.tune_mode     = mode_q;
          rsp_d.station_count = spst_pkg::IDX_OUT_W'(count_q);
          rsp_d.save_pending  = sdirty_q || ldirty_q;
        end
      end
      default: ok_d = ok_q;
    endcase

    e0_valid_d = e0_valid_q || (ram_we && ram_waddr == '0);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spst_pkg::ST_IDLE;
      count_q     <= CW'(1);
      preset_q    <= '0;
      freq_q      <= spst_pkg::RESET_DEFAULT;
      mode_q      <= '0;
      sdirty_q    <= 1'b0;
      ldirty_q    <= 1'b0;
      e0_valid_q  <= 1'b0;
      fix_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      preset_q    <= preset_d;
      freq_q      <= freq_d;
      mode_q      <= mode_d;
      sdirty_q    <= sdirty_d;
      ldirty_q    <= ldirty_d;
      e0_valid_q  <= e0_valid_d;
      fix_q       <= (ram_raddr == '0) && !e0_valid_q;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    ok_q  <= ok_d;
    rsp_q <= rsp_d;
  end

`ifndef ASSERT_OFF
  // table never holds more than its depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_STATIONS))
    else $error("station count above table depth");

  // a waiting response is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spst_pkg::ST_DONE && rsp_valid_q && !rsp_ready_i) |=>
      (state_q == spst_pkg::ST_DONE))
    else $error("response register overwritten while stalled");

  // an insert that places a station grows the table by one
  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spst_pkg::ST_PUT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the table");

  // only a full table can refuse a new in-range station after the search
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spst_pkg::ST_SHIFT_UP) |-> !full)
    else $error("shift started on a full table");
`endif

endmodule
